>>> design/jqc_pkg.sv
// Shared types and constants for the job queue with cancel.
// Used by jqc_ctrl, jqc_dp and job_queue_with_cancel; depends on nothing.
package jqc_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;

    localparam int CMD_W = 3;
    localparam int KEY_W = 32;
    localparam int ST_W  = 2;
    localparam int OCC_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ    = 3'd0,
        CMD_DEQ    = 3'd1,
        CMD_CANCEL = 3'd2,
        CMD_HEAD   = 3'd3,
        CMD_LIST   = 3'd4
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KS_ZERO = 2'd0,
        KS_RD   = 2'd1,
        KS_HOLD = 2'd2
    } t_key_src;

    typedef struct packed {
        logic     load_in;
        logic     ptr_clr;
        logic     ptr_inc;
        logic     rd_en;
        logic     rd_next;
        logic     wr_en;
        logic     wr_key;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     hold_load;
        logic     out_load;
        t_status  out_status;
        t_key_src out_src;
        logic     out_last;
    } t_dp_ctrl;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic ptr_end;
        logic ptr_at_last;
        logic match;
        logic out_free;
    } t_dp_stat;

endpackage

>>> design/jqc_dp.sv
// Datapath of the job queue: entry memory, count, index pointer, output word register.
// Depends on jqc_pkg; driven by jqc_ctrl.
module jqc_dp #(
    parameter int DEPTH    = jqc_pkg::DEPTH_DEF,
    parameter int KEY_BITS = jqc_pkg::KEY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [jqc_pkg::KEY_W-1:0]   i_job_key,
    input  jqc_pkg::t_dp_ctrl           i_ctrl,
    output jqc_pkg::t_dp_stat           o_stat,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [jqc_pkg::ST_W-1:0]    o_status,
    output logic [jqc_pkg::KEY_W-1:0]   o_result_key,
    output logic                        o_last,
    output logic [jqc_pkg::OCC_W-1:0]   o_occupancy
);

    localparam int KW = (KEY_BITS < jqc_pkg::KEY_W) ? KEY_BITS : jqc_pkg::KEY_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [KW-1:0] r_mem [DEPTH];
    logic [KW-1:0] r_rd_data;
    logic [KW-1:0] r_key;
    logic [KW-1:0] r_hold;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;

    logic                      r_out_valid;
    logic [jqc_pkg::ST_W-1:0]  r_status;
    logic [jqc_pkg::KEY_W-1:0] r_result_key;
    logic                      r_last;
    logic [jqc_pkg::OCC_W-1:0] r_occupancy;

    logic [CW:0]                 ptr_plus1;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic [KW-1:0]               wr_data;
    logic [jqc_pkg::KEY_W-1:0]   out_key;

    assign ptr_plus1 = {1'b0, r_ptr} + (CW+1)'(1);
    assign rd_addr   = i_ctrl.rd_next ? ptr_plus1[AW-1:0] : r_ptr[AW-1:0];
    assign wr_addr   = i_ctrl.wr_key ? r_count[AW-1:0] : r_ptr[AW-1:0];
    assign wr_data   = i_ctrl.wr_key ? r_key : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_key <= KW'(i_job_key);
        end
        if (i_ctrl.hold_load) begin
            r_hold <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            if (i_ctrl.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_ctrl.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_ctrl.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_ctrl.ptr_inc) begin
                r_ptr <= r_ptr + CW'(1);
            end
        end
    end

    always_comb begin
        case (i_ctrl.out_src)
            jqc_pkg::KS_ZERO: out_key = '0;
            jqc_pkg::KS_RD:   out_key = jqc_pkg::KEY_W'(r_rd_data);
            jqc_pkg::KS_HOLD: out_key = jqc_pkg::KEY_W'(r_hold);
            default:          out_key = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_status     <= i_ctrl.out_status;
            r_result_key <= out_key;
            r_last       <= i_ctrl.out_last;
            r_occupancy  <= jqc_pkg::OCC_W'(r_count);
        end
    end

    assign o_stat.count_zero  = (r_count == '0);
    assign o_stat.full        = (r_count == CW'(DEPTH));
    assign o_stat.ptr_end     = (r_ptr == r_count);
    assign o_stat.ptr_at_last = (ptr_plus1 == {1'b0, r_count});
    assign o_stat.match       = (r_rd_data == r_key);
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_result_key = r_result_key;
    assign o_last       = r_last;
    assign o_occupancy  = r_occupancy;

endmodule

>>> design/jqc_ctrl.sv
// Controller state machine of the job queue: decodes commands, sequences
// search, shift and list walks. Depends on jqc_pkg; drives jqc_dp.
module jqc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [jqc_pkg::CMD_W-1:0]   i_command,
    output logic                        o_in_stall,
    input  jqc_pkg::t_dp_stat           i_stat,
    output jqc_pkg::t_dp_ctrl           o_ctrl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_WR,
        S_HEAD_RD,
        S_HEAD_CAP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_LIST_RD,
        S_LIST_OUT,
        S_RESP
    } t_state;

    t_state             r_state, n_state;
    jqc_pkg::t_cmd      r_op, n_op;
    jqc_pkg::t_status   r_status, n_status;
    jqc_pkg::t_key_src  r_src, n_src;

    logic accept;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        n_src    = r_src;
        o_ctrl   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_ctrl.load_in = 1'b1;
                    o_ctrl.ptr_clr = 1'b1;
                    n_op           = jqc_pkg::t_cmd'(i_command);
                    n_src          = jqc_pkg::KS_ZERO;
                    case (jqc_pkg::t_cmd'(i_command))
                        jqc_pkg::CMD_ENQ: begin
                            if (i_stat.full) begin
                                n_status = jqc_pkg::ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_state  = S_ENQ_WR;
                            end
                        end
                        jqc_pkg::CMD_DEQ, jqc_pkg::CMD_HEAD: begin
                            if (i_stat.count_zero) begin
                                n_status = jqc_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state  = S_HEAD_RD;
                            end
                        end
                        jqc_pkg::CMD_CANCEL: begin
                            n_state = S_SCAN_RD;
                        end
                        jqc_pkg::CMD_LIST: begin
                            if (i_stat.count_zero) begin
                                n_status = jqc_pkg::ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state  = S_LIST_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ENQ_WR: begin
                o_ctrl.wr_en   = 1'b1;
                o_ctrl.wr_key  = 1'b1;
                o_ctrl.cnt_inc = 1'b1;
                n_status       = jqc_pkg::ST_OK;
                n_src          = jqc_pkg::KS_ZERO;
                n_state        = S_RESP;
            end
            S_HEAD_RD: begin
                o_ctrl.rd_en = 1'b1;
                n_state      = S_HEAD_CAP;
            end
            S_HEAD_CAP: begin
                o_ctrl.hold_load = 1'b1;
                n_status         = jqc_pkg::ST_OK;
                n_src            = jqc_pkg::KS_HOLD;
                n_state          = (r_op == jqc_pkg::CMD_DEQ) ? S_SHIFT_RD : S_RESP;
            end
            S_SCAN_RD: begin
                if (i_stat.ptr_end) begin
                    n_status = jqc_pkg::ST_NOTFOUND;
                    n_src    = jqc_pkg::KS_ZERO;
                    n_state  = S_RESP;
                end else begin
                    o_ctrl.rd_en = 1'b1;
                    n_state      = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.match) begin
                    n_status = jqc_pkg::ST_OK;
                    n_src    = jqc_pkg::KS_ZERO;
                    n_state  = S_SHIFT_RD;
                end else begin
                    o_ctrl.ptr_inc = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.ptr_at_last) begin
                    o_ctrl.cnt_dec = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    o_ctrl.rd_en   = 1'b1;
                    o_ctrl.rd_next = 1'b1;
                    n_state        = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_ctrl.wr_en   = 1'b1;
                o_ctrl.ptr_inc = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_LIST_RD: begin
                o_ctrl.rd_en = 1'b1;
                n_state      = S_LIST_OUT;
            end
            S_LIST_OUT: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load   = 1'b1;
                    o_ctrl.out_status = jqc_pkg::ST_OK;
                    o_ctrl.out_src    = jqc_pkg::KS_RD;
                    o_ctrl.out_last   = i_stat.ptr_at_last;
                    if (i_stat.ptr_at_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctrl.ptr_inc = 1'b1;
                        n_state        = S_LIST_RD;
                    end
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load   = 1'b1;
                    o_ctrl.out_status = r_status;
                    o_ctrl.out_src    = r_src;
                    o_ctrl.out_last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= jqc_pkg::CMD_ENQ;
            r_status <= jqc_pkg::ST_OK;
            r_src    <= jqc_pkg::KS_ZERO;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_status <= n_status;
            r_src    <= n_src;
        end
    end

endmodule

>>> design/job_queue_with_cancel.sv
// Top level of the job queue with cancel: controller plus datapath.
// Depends on jqc_pkg, jqc_ctrl and jqc_dp.
//
// Usage: the input channel (i_in_valid / o_in_stall) takes one word with a
// command (enqueue, dequeue, cancel, head, list) and a job key. The output
// channel (o_out_valid / i_out_stall) returns status, key, last flag and the
// occupancy after the command. Every command gives one result word, list
// gives one per entry with o_last on the final one (one empty-status word if
// the queue is empty); codes 5..7 give none. One item is in work at a time;
// the entry memory has a registered read, and each entry moved by dequeue or
// cancel is read in one state and written back one slot lower in the next.
// Cancel reads and compares the entries in order until one matches the key.
// Reset (synchronous, active low) empties the queue and drops any pending
// output word; memory contents are not cleared and need no clearing pass.
// While the receiver stalls, the output word holds and the block waits
// before loading the next word; o_in_stall stays high until the item is done.
module job_queue_with_cancel #(
    parameter int DEPTH    = jqc_pkg::DEPTH_DEF,
    parameter int KEY_BITS = jqc_pkg::KEY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [jqc_pkg::CMD_W-1:0]   i_command,
    input  logic [jqc_pkg::KEY_W-1:0]   i_job_key,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [jqc_pkg::ST_W-1:0]    o_status,
    output logic [jqc_pkg::KEY_W-1:0]   o_result_key,
    output logic                        o_last,
    output logic [jqc_pkg::OCC_W-1:0]   o_occupancy
);

    jqc_pkg::t_dp_ctrl ctrl;
    jqc_pkg::t_dp_stat stat;

    jqc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    jqc_dp #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_key    (i_job_key),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_result_key (o_result_key),
        .o_last       (o_last),
        .o_occupancy  (o_occupancy)
    );

    a_err_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != jqc_pkg::ST_OK) |-> o_result_key == '0)
        else $error("non-ok result carries a key");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == jqc_pkg::ST_EMPTY) |-> o_occupancy == '0)
        else $error("empty status with nonzero occupancy");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == jqc_pkg::ST_FULL)
            |-> o_occupancy == jqc_pkg::OCC_W'(DEPTH))
        else $error("full status without a full queue");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |-> stat.out_free)
        else $error("output word overwritten while stalled");

endmodule
